// ===== design/ffha_pkg.sv =====
// Shared types, codes and default sizes for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp and first_fit_heap_allocator; no dependencies.
`default_nettype none

package ffha_pkg;

   // Default sizes of the heap and its tables.
   localparam int HEAP_BYTES_DEF   = 1048576;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int MAX_FREE_DEF     = 32;
   localparam int MAX_LIVE_DEF     = 64;

   // Field widths.
   localparam int ADDR_W = 20;
   localparam int SIZE_W = 21;
   localparam int STAT_W = 3;
   localparam int CALC_W = 23;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] ST_NULL    = 3'd3;
   localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

   // Request and response payloads.
   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] grant_address;
      logic [STAT_W-1:0] status;
   } rsp_type;

   // One table entry: start offset and payload length.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] len;
   } entry_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_A_SLOT,
      S_A_FRD,
      S_A_FCHK,
      S_A_BRK,
      S_A_SPLIT,
      S_LIVE_WR,
      S_R_CHK,
      S_R_CMP,
      S_I_RD,
      S_I_CHK,
      S_I_DEC,
      S_SH_RD,
      S_SH_WR,
      S_REM_RD,
      S_REM_WR,
      S_I_DONE,
      S_DONE
   } ctrl_state_type;

   // Datapath micro-operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SLOT_NEXT,
      OP_SLOT_TAKE,
      OP_FRD,
      OP_FIT_TAKE,
      OP_FNEXT,
      OP_REM_RD,
      OP_REM_WR,
      OP_REM_END,
      OP_SPLIT,
      OP_BRK,
      OP_LIVE_WR,
      OP_LRD,
      OP_LNEXT,
      OP_LHIT,
      OP_IPREV,
      OP_IKEY,
      OP_MERGE_BOTH,
      OP_MERGE_FRONT,
      OP_MERGE_BACK,
      OP_SH_START,
      OP_SH_RD,
      OP_SH_WR,
      OP_SH_END,
      OP_REL_OK,
      OP_ST_FULL,
      OP_ST_NOSPACE,
      OP_ST_NULL,
      OP_ST_UNKNOWN,
      OP_PUBLISH
   } dp_op_type;

   // Status flags returned by the datapath.
   typedef struct packed {
      logic mode;
      logic null_addr;
      logic slot_free;
      logic slot_last;
      logic idx_eq_fcnt;
      logic fit;
      logic split;
      logic nospace;
      logic live_end;
      logic live_valid;
      logic live_hit;
      logic rd_lt;
      logic front;
      logic back;
      logic fcnt_full;
      logic rem_done;
      logic sh_done;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== design/ffha_ctrl.sv =====
// Controller state machine of the heap allocator: sequences the datapath.
// Depends on ffha_pkg.
`default_nettype none

module ffha_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  ffha_pkg::dp_stat_type  stat,
   output ffha_pkg::dp_op_type    op
);

   ffha_pkg::ctrl_state_type state_ff, state_in;
   logic ins_ff, ins_in;

   // State and insert-context registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_IDLE;
         ins_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ins_ff   <= ins_in;
      end
   end

   // The insert context marks a removal that finishes a double merge.
   always_comb begin
      ins_in = ins_ff;
      if (op == ffha_pkg::OP_LOAD) begin
         ins_in = 1'b0;
      end else if (op == ffha_pkg::OP_SPLIT || op == ffha_pkg::OP_LHIT) begin
         ins_in = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid) state_in = ffha_pkg::S_DISPATCH;
         end
         ffha_pkg::S_DISPATCH: begin
            if (!stat.mode) state_in = ffha_pkg::S_A_SLOT;
            else if (stat.null_addr) state_in = ffha_pkg::S_DONE;
            else state_in = ffha_pkg::S_R_CHK;
         end
         ffha_pkg::S_A_SLOT: begin
            if (stat.slot_free) state_in = ffha_pkg::S_A_FRD;
            else if (stat.slot_last) state_in = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_A_FRD: begin
            state_in = stat.idx_eq_fcnt ? ffha_pkg::S_A_BRK : ffha_pkg::S_A_FCHK;
         end
         ffha_pkg::S_A_FCHK: begin
            state_in = stat.fit ? ffha_pkg::S_REM_RD : ffha_pkg::S_A_FRD;
         end
         ffha_pkg::S_A_BRK: begin
            state_in = stat.nospace ? ffha_pkg::S_DONE : ffha_pkg::S_LIVE_WR;
         end
         ffha_pkg::S_REM_RD: begin
            if (stat.rem_done) begin
               state_in = ins_ff ? ffha_pkg::S_I_DONE : ffha_pkg::S_A_SPLIT;
            end else begin
               state_in = ffha_pkg::S_REM_WR;
            end
         end
         ffha_pkg::S_REM_WR: state_in = ffha_pkg::S_REM_RD;
         ffha_pkg::S_A_SPLIT: begin
            state_in = stat.split ? ffha_pkg::S_I_RD : ffha_pkg::S_LIVE_WR;
         end
         ffha_pkg::S_LIVE_WR: state_in = ffha_pkg::S_DONE;
         ffha_pkg::S_R_CHK: begin
            if (stat.live_end) state_in = ffha_pkg::S_DONE;
            else if (stat.live_valid) state_in = ffha_pkg::S_R_CMP;
         end
         ffha_pkg::S_R_CMP: begin
            state_in = stat.live_hit ? ffha_pkg::S_I_RD : ffha_pkg::S_R_CHK;
         end
         ffha_pkg::S_I_RD: begin
            state_in = stat.idx_eq_fcnt ? ffha_pkg::S_I_DEC : ffha_pkg::S_I_CHK;
         end
         ffha_pkg::S_I_CHK: begin
            state_in = stat.rd_lt ? ffha_pkg::S_I_RD : ffha_pkg::S_I_DEC;
         end
         ffha_pkg::S_I_DEC: begin
            if (stat.front && stat.back) state_in = ffha_pkg::S_REM_RD;
            else if (stat.front || stat.back) state_in = ffha_pkg::S_I_DONE;
            else if (stat.fcnt_full) begin
               state_in = stat.mode ? ffha_pkg::S_DONE : ffha_pkg::S_LIVE_WR;
            end else state_in = ffha_pkg::S_SH_RD;
         end
         ffha_pkg::S_SH_RD: begin
            state_in = stat.sh_done ? ffha_pkg::S_I_DONE : ffha_pkg::S_SH_WR;
         end
         ffha_pkg::S_SH_WR: state_in = ffha_pkg::S_SH_RD;
         ffha_pkg::S_I_DONE: begin
            state_in = stat.mode ? ffha_pkg::S_DONE : ffha_pkg::S_LIVE_WR;
         end
         ffha_pkg::S_DONE: begin
            if (stat.out_free) state_in = ffha_pkg::S_IDLE;
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
   end

   // Datapath command for the current state.
   always_comb begin
      op = ffha_pkg::OP_NONE;
      case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid) op = ffha_pkg::OP_LOAD;
         end
         ffha_pkg::S_DISPATCH: begin
            if (stat.mode && stat.null_addr) op = ffha_pkg::OP_ST_NULL;
         end
         ffha_pkg::S_A_SLOT: begin
            if (stat.slot_free) op = ffha_pkg::OP_SLOT_TAKE;
            else if (stat.slot_last) op = ffha_pkg::OP_ST_FULL;
            else op = ffha_pkg::OP_SLOT_NEXT;
         end
         ffha_pkg::S_A_FRD: begin
            if (!stat.idx_eq_fcnt) op = ffha_pkg::OP_FRD;
         end
         ffha_pkg::S_A_FCHK: begin
            op = stat.fit ? ffha_pkg::OP_FIT_TAKE : ffha_pkg::OP_FNEXT;
         end
         ffha_pkg::S_A_BRK: begin
            op = stat.nospace ? ffha_pkg::OP_ST_NOSPACE : ffha_pkg::OP_BRK;
         end
         ffha_pkg::S_REM_RD: begin
            op = stat.rem_done ? ffha_pkg::OP_REM_END : ffha_pkg::OP_REM_RD;
         end
         ffha_pkg::S_REM_WR: op = ffha_pkg::OP_REM_WR;
         ffha_pkg::S_A_SPLIT: begin
            if (stat.split) op = ffha_pkg::OP_SPLIT;
         end
         ffha_pkg::S_LIVE_WR: op = ffha_pkg::OP_LIVE_WR;
         ffha_pkg::S_R_CHK: begin
            if (stat.live_end) op = ffha_pkg::OP_ST_UNKNOWN;
            else if (stat.live_valid) op = ffha_pkg::OP_LRD;
            else op = ffha_pkg::OP_LNEXT;
         end
         ffha_pkg::S_R_CMP: begin
            op = stat.live_hit ? ffha_pkg::OP_LHIT : ffha_pkg::OP_LNEXT;
         end
         ffha_pkg::S_I_RD: begin
            op = stat.idx_eq_fcnt ? ffha_pkg::OP_IKEY : ffha_pkg::OP_FRD;
         end
         ffha_pkg::S_I_CHK: begin
            op = stat.rd_lt ? ffha_pkg::OP_IPREV : ffha_pkg::OP_IKEY;
         end
         ffha_pkg::S_I_DEC: begin
            if (stat.front && stat.back) op = ffha_pkg::OP_MERGE_BOTH;
            else if (stat.front) op = ffha_pkg::OP_MERGE_FRONT;
            else if (stat.back) op = ffha_pkg::OP_MERGE_BACK;
            else if (stat.fcnt_full) begin
               if (stat.mode) op = ffha_pkg::OP_ST_FULL;
            end else op = ffha_pkg::OP_SH_START;
         end
         ffha_pkg::S_SH_RD: begin
            op = stat.sh_done ? ffha_pkg::OP_SH_END : ffha_pkg::OP_SH_RD;
         end
         ffha_pkg::S_SH_WR: op = ffha_pkg::OP_SH_WR;
         ffha_pkg::S_I_DONE: begin
            if (stat.mode) op = ffha_pkg::OP_REL_OK;
         end
         ffha_pkg::S_DONE: begin
            if (stat.out_free) op = ffha_pkg::OP_PUBLISH;
         end
         default: op = ffha_pkg::OP_NONE;
      endcase
   end

   // A new request is taken only between requests.
   assign req_stall = (state_ff != ffha_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== design/ffha_dp.sv =====
// Datapath of the heap allocator: free and live tables, break pointer,
// index counters and the response register. Depends on ffha_pkg.
`default_nettype none

module ffha_dp #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int MAX_FREE     = ffha_pkg::MAX_FREE_DEF,
   parameter int MAX_LIVE     = ffha_pkg::MAX_LIVE_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  ffha_pkg::req_type      req_data,
   input  ffha_pkg::dp_op_type    op,
   output ffha_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ffha_pkg::rsp_type      rsp_data
);

   localparam int AW = ffha_pkg::ADDR_W;
   localparam int SW = ffha_pkg::SIZE_W;
   localparam int CW = ffha_pkg::CALC_W;
   localparam int FW = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
   localparam int NW = $clog2(MAX_FREE + 1);
   localparam int LW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
   localparam int IW = $clog2(((MAX_FREE > MAX_LIVE) ? MAX_FREE : MAX_LIVE) + 1);
   localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] HEAP = CW'(HEAP_BYTES);

   // Free and live tables.
   ffha_pkg::entry_type free_mem [MAX_FREE];
   ffha_pkg::entry_type live_mem [MAX_LIVE];

   // Control registers.
   logic [NW-1:0]       fcnt_ff, fcnt_in;
   logic [SW-1:0]       brk_ff, brk_in;
   logic [MAX_LIVE-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers.
   ffha_pkg::req_type   req_ff, req_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       k_ff, k_in;
   logic [LW-1:0]       slot_ff, slot_in;
   logic [AW-1:0]       s_ff, s_in;
   logic [SW-1:0]       len_ff, len_in;
   logic [AW-1:0]       ins_s_ff, ins_s_in;
   logic [SW-1:0]       ins_len_ff, ins_len_in;
   ffha_pkg::entry_type pv_ff, pv_in;
   logic                pv_ok_ff, pv_ok_in;
   ffha_pkg::entry_type cur_ff, cur_in;
   logic [AW-1:0]       grant_ff, grant_in;
   logic [ffha_pkg::STAT_W-1:0] res_st_ff, res_st_in;
   ffha_pkg::rsp_type   rsp_ff, rsp_in;
   ffha_pkg::entry_type frd_ff, lrd_ff;

   // Memory port controls.
   logic                fre, fwe, lre, lwe;
   logic [FW-1:0]       fra, fwa;
   ffha_pkg::entry_type fwd, lwd;

   // Arithmetic shared by several operations.
   logic [IW-1:0] idx_p1, idx_m1, k_m1;
   logic [CW-1:0] req_c, len_c, ins_len_c, ins_s_c, brk_c, s_c;
   logic [CW-1:0] pv_end, ins_end, len_front, len_both, len_back;

   assign idx_p1    = idx_ff + 1'b1;
   assign idx_m1    = idx_ff - 1'b1;
   assign k_m1      = k_ff - 1'b1;
   assign req_c     = CW'(req_ff.req_size);
   assign len_c     = CW'(len_ff);
   assign ins_len_c = CW'(ins_len_ff);
   assign ins_s_c   = CW'(ins_s_ff);
   assign brk_c     = CW'(brk_ff);
   assign s_c       = CW'(s_ff);
   assign pv_end    = CW'(pv_ff.start) + HDR + CW'(pv_ff.len);
   assign ins_end   = ins_s_c + HDR + ins_len_c;
   assign len_front = CW'(pv_ff.len) + HDR + ins_len_c;
   assign len_back  = ins_len_c + HDR + CW'(cur_ff.len);
   assign len_both  = len_front + HDR + CW'(cur_ff.len);

   // Status toward the controller.
   always_comb begin
      stat.mode        = req_ff.mode;
      stat.null_addr   = (req_ff.address == '0);
      stat.slot_free   = !valid_ff[idx_ff[LW-1:0]];
      stat.slot_last   = (idx_ff == IW'(MAX_LIVE - 1));
      stat.idx_eq_fcnt = (idx_ff == IW'(fcnt_ff));
      stat.fit         = (frd_ff.len >= req_ff.req_size);
      stat.split       = (len_c > req_c + HDR);
      stat.nospace     = (brk_c + HDR + req_c > HEAP) || (brk_c + HDR >= HEAP);
      stat.live_end    = (idx_ff == IW'(MAX_LIVE));
      stat.live_valid  = valid_ff[idx_ff[LW-1:0]];
      stat.live_hit    = (lrd_ff.start == req_ff.address);
      stat.rd_lt       = (frd_ff.start < ins_s_ff);
      stat.front       = pv_ok_ff && (pv_end == ins_s_c);
      stat.back        = (k_ff < IW'(fcnt_ff)) && (ins_end == CW'(cur_ff.start));
      stat.fcnt_full   = (fcnt_ff == NW'(MAX_FREE));
      stat.rem_done    = (idx_p1 >= IW'(fcnt_ff));
      stat.sh_done     = (idx_ff == k_ff);
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Free table port selection.
   always_comb begin
      fre = 1'b0;
      fra = idx_ff[FW-1:0];
      fwe = 1'b0;
      fwa = idx_ff[FW-1:0];
      fwd = frd_ff;
      case (op)
         ffha_pkg::OP_FRD: fre = 1'b1;
         ffha_pkg::OP_REM_RD: begin
            fre = 1'b1;
            fra = idx_p1[FW-1:0];
         end
         ffha_pkg::OP_SH_RD: begin
            fre = 1'b1;
            fra = idx_m1[FW-1:0];
         end
         ffha_pkg::OP_REM_WR, ffha_pkg::OP_SH_WR: fwe = 1'b1;
         ffha_pkg::OP_MERGE_BOTH: begin
            fwe = 1'b1;
            fwa = k_m1[FW-1:0];
            fwd = '{start: pv_ff.start, len: len_both[SW-1:0]};
         end
         ffha_pkg::OP_MERGE_FRONT: begin
            fwe = 1'b1;
            fwa = k_m1[FW-1:0];
            fwd = '{start: pv_ff.start, len: len_front[SW-1:0]};
         end
         ffha_pkg::OP_MERGE_BACK: begin
            fwe = 1'b1;
            fwa = k_ff[FW-1:0];
            fwd = '{start: ins_s_ff, len: len_back[SW-1:0]};
         end
         ffha_pkg::OP_SH_END: begin
            fwe = 1'b1;
            fwa = k_ff[FW-1:0];
            fwd = '{start: ins_s_ff, len: ins_len_ff};
         end
         default: fre = 1'b0;
      endcase
   end

   // Live table port selection.
   always_comb begin
      lre = (op == ffha_pkg::OP_LRD);
      lwe = (op == ffha_pkg::OP_LIVE_WR);
      lwd = '{start: AW'(s_c + HDR), len: len_ff};
   end

   // Table memories with registered read data.
   always_ff @(posedge clock) begin
      if (fwe) free_mem[fwa] <= fwd;
      if (fre) frd_ff <= free_mem[fra];
   end

   always_ff @(posedge clock) begin
      if (lwe) live_mem[slot_ff] <= lwd;
      if (lre) lrd_ff <= live_mem[idx_ff[LW-1:0]];
   end

   // Next values of all datapath registers.
   always_comb begin
      fcnt_in      = fcnt_ff;
      brk_in       = brk_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_in       = req_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      slot_in      = slot_ff;
      s_in         = s_ff;
      len_in       = len_ff;
      ins_s_in     = ins_s_ff;
      ins_len_in   = ins_len_ff;
      pv_in        = pv_ff;
      pv_ok_in     = pv_ok_ff;
      cur_in       = cur_ff;
      grant_in     = grant_ff;
      res_st_in    = res_st_ff;
      rsp_in       = rsp_ff;
      case (op)
         ffha_pkg::OP_LOAD: begin
            req_in   = req_data;
            idx_in   = '0;
            grant_in = '0;
         end
         ffha_pkg::OP_SLOT_NEXT, ffha_pkg::OP_FNEXT, ffha_pkg::OP_LNEXT,
         ffha_pkg::OP_REM_WR: idx_in = idx_p1;
         ffha_pkg::OP_SLOT_TAKE: begin
            slot_in = idx_ff[LW-1:0];
            idx_in  = '0;
         end
         ffha_pkg::OP_FIT_TAKE: begin
            s_in   = frd_ff.start;
            len_in = frd_ff.len;
         end
         ffha_pkg::OP_REM_END: fcnt_in = fcnt_ff - 1'b1;
         ffha_pkg::OP_SPLIT: begin
            ins_s_in   = AW'(s_c + HDR + req_c);
            ins_len_in = SW'(len_c - req_c - HDR);
            len_in     = req_ff.req_size;
            idx_in     = '0;
            pv_ok_in   = 1'b0;
         end
         ffha_pkg::OP_BRK: begin
            s_in   = brk_ff[AW-1:0];
            len_in = req_ff.req_size;
            brk_in = SW'(brk_c + HDR + req_c);
         end
         ffha_pkg::OP_LIVE_WR: begin
            valid_in[slot_ff] = 1'b1;
            grant_in          = AW'(s_c + HDR);
            res_st_in         = ffha_pkg::ST_OK;
         end
         ffha_pkg::OP_LHIT: begin
            slot_in    = idx_ff[LW-1:0];
            ins_s_in   = AW'(CW'(req_ff.address) - HDR);
            ins_len_in = lrd_ff.len;
            idx_in     = '0;
            pv_ok_in   = 1'b0;
         end
         ffha_pkg::OP_IPREV: begin
            pv_in    = frd_ff;
            pv_ok_in = 1'b1;
            idx_in   = idx_p1;
         end
         ffha_pkg::OP_IKEY: begin
            k_in   = idx_ff;
            cur_in = frd_ff;
         end
         ffha_pkg::OP_MERGE_BOTH: idx_in = k_ff;
         ffha_pkg::OP_SH_START: idx_in = IW'(fcnt_ff);
         ffha_pkg::OP_SH_WR: idx_in = idx_m1;
         ffha_pkg::OP_SH_END: fcnt_in = fcnt_ff + 1'b1;
         ffha_pkg::OP_REL_OK: begin
            valid_in[slot_ff] = 1'b0;
            res_st_in         = ffha_pkg::ST_OK;
         end
         ffha_pkg::OP_ST_FULL: res_st_in = ffha_pkg::ST_FULL;
         ffha_pkg::OP_ST_NOSPACE: res_st_in = ffha_pkg::ST_NOSPACE;
         ffha_pkg::OP_ST_NULL: res_st_in = ffha_pkg::ST_NULL;
         ffha_pkg::OP_ST_UNKNOWN: res_st_in = ffha_pkg::ST_UNKNOWN;
         ffha_pkg::OP_PUBLISH: begin
            rsp_in       = '{grant_address: grant_ff, status: res_st_ff};
            rsp_valid_in = 1'b1;
         end
         default: idx_in = idx_ff;
      endcase
   end

   // Control registers cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff      <= '0;
         brk_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fcnt_ff      <= fcnt_in;
         brk_ff       <= brk_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      slot_ff    <= slot_in;
      s_ff       <= s_in;
      len_ff     <= len_in;
      ins_s_ff   <= ins_s_in;
      ins_len_ff <= ins_len_in;
      pv_ff      <= pv_in;
      pv_ok_ff   <= pv_ok_in;
      cur_ff     <= cur_in;
      grant_ff   <= grant_in;
      res_st_ff  <= res_st_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing: top level.
// Joins ffha_ctrl and ffha_dp; depends on ffha_pkg.
//
// Usage: a request on req_ (mode 0 allocate req_size bytes, mode 1 release
// the block at address) is taken when req_valid is high and req_stall low.
// Exactly one response per request leaves on rsp_ with grant_address and
// status, held until rsp_valid is high with rsp_stall low.
// One request is worked at a time. An allocate finds a free live slot,
// scans the free entries for a fit, shifts entries down on removal and
// scans and shifts to insert a split remainder. A release scans the live
// entries (MAX_LIVE at most) and inserts the freed block, merging it with
// its neighbours. The free table has one read and one write port.
// Reset empties both tables and the break pointer at once; the first
// request may follow right away. While the receiver stalls, the finished
// response is held and the block takes the next request, finishing its work
// but waiting to publish until the output register is free.
`default_nettype none

module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int MAX_FREE     = ffha_pkg::MAX_FREE_DEF,
   parameter int MAX_LIVE     = ffha_pkg::MAX_LIVE_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  ffha_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output ffha_pkg::rsp_type  rsp_data
);

   ffha_pkg::dp_op_type   op;
   ffha_pkg::dp_stat_type stat;

   // Sequencer.
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .op        (op)
   );

   // Tables and arithmetic.
   ffha_dp #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_FREE     (MAX_FREE),
      .MAX_LIVE     (MAX_LIVE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .op        (op),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for first_fit_heap_allocator with default sizes.
// Predicts every response from a behavioral heap model; depends on ffha_pkg.
`default_nettype none

module tb;

   localparam int HEAP   = ffha_pkg::HEAP_BYTES_DEF;
   localparam int HDR    = ffha_pkg::HEADER_BYTES_DEF;
   localparam int NFREE  = ffha_pkg::MAX_FREE_DEF;
   localparam int NLIVE  = ffha_pkg::MAX_LIVE_DEF;
   localparam int AW     = ffha_pkg::ADDR_W;
   localparam int SW     = ffha_pkg::SIZE_W;
   localparam int WATCHDOG_LIMIT = 200000;

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ffha_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   ffha_pkg::rsp_type rsp_data;

   first_fit_heap_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Predicted heap state; all of it starts at zero.
   int unsigned brk_ptr;
   int unsigned fr_start [NFREE];
   int unsigned fr_len [NFREE];
   int unsigned fr_cnt;
   int unsigned lv_start [NLIVE];
   int unsigned lv_len [NLIVE];
   bit          lv_used [NLIVE];

   ffha_pkg::req_type pending_reqs[$];
   ffha_pkg::rsp_type expected_rsps[$];
   int unsigned       granted_addrs[$];
   int                mismatches;
   int                sent_count;
   int                watchdog;
   bit                drain_hold;
   bit                quiet_phase;

   // Clock.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Free-list maintenance.
   function automatic void free_drop(int unsigned k);
      for (int unsigned i = k; i + 1 < fr_cnt; i++) begin
         fr_start[i] = fr_start[i+1];
         fr_len[i]   = fr_len[i+1];
      end
      fr_cnt--;
   endfunction

   function automatic bit free_add(int unsigned s, int unsigned len);
      int unsigned k;
      bit front, back;
      k = 0;
      while (k < fr_cnt && fr_start[k] < s) k++;
      front = k > 0 && fr_start[k-1] + HDR + fr_len[k-1] == s;
      back  = k < fr_cnt && s + HDR + len == fr_start[k];
      if (front && back) begin
         fr_len[k-1] += HDR + len + HDR + fr_len[k];
         free_drop(k);
      end else if (front) begin
         fr_len[k-1] += HDR + len;
      end else if (back) begin
         fr_start[k] = s;
         fr_len[k]   = len + HDR + fr_len[k];
      end else begin
         if (fr_cnt >= NFREE) return 1'b0;
         for (int unsigned i = fr_cnt; i > k; i--) begin
            fr_start[i] = fr_start[i-1];
            fr_len[i]   = fr_len[i-1];
         end
         fr_start[k] = s;
         fr_len[k]   = len;
         fr_cnt++;
      end
      return 1'b1;
   endfunction

   // Computes the response of one request and updates the predicted heap.
   function automatic ffha_pkg::rsp_type heap_predict(ffha_pkg::req_type r);
      ffha_pkg::rsp_type o;
      int                slot;
      int unsigned       k, s, len, req;
      longint unsigned   top;
      o.grant_address = '0;
      o.status        = ffha_pkg::ST_OK;
      req = r.req_size;
      if (r.mode == MODE_ALLOC) begin
         slot = -1;
         for (int i = 0; i < NLIVE; i++)
            if (!lv_used[i] && slot < 0) slot = i;
         if (slot < 0) begin
            o.status = ffha_pkg::ST_FULL;
            return o;
         end
         k = 0;
         while (k < fr_cnt && fr_len[k] < req) k++;
         if (k < fr_cnt) begin
            s   = fr_start[k];
            len = fr_len[k];
            free_drop(k);
            if (len > req + HDR) begin
               void'(free_add(s + HDR + req, len - req - HDR));
               len = req;
            end
         end else begin
            s   = brk_ptr;
            top = longint'(s) + HDR + req;
            if (top > HEAP || s + HDR >= HEAP) begin
               o.status = ffha_pkg::ST_NOSPACE;
               return o;
            end
            len     = req;
            brk_ptr = s + HDR + req;
         end
         lv_used[slot]   = 1'b1;
         lv_start[slot]  = s + HDR;
         lv_len[slot]    = len;
         o.grant_address = AW'(s + HDR);
         granted_addrs.push_back(s + HDR);
      end else begin
         if (r.address == 0) begin
            o.status = ffha_pkg::ST_NULL;
            return o;
         end
         slot = -1;
         for (int i = 0; i < NLIVE; i++)
            if (lv_used[i] && lv_start[i] == r.address && slot < 0) slot = i;
         if (slot < 0) o.status = ffha_pkg::ST_UNKNOWN;
         else if (!free_add(r.address - HDR, lv_len[slot])) o.status = ffha_pkg::ST_FULL;
         else lv_used[slot] = 1'b0;
      end
      return o;
   endfunction

   function automatic ffha_pkg::req_type make_alloc(int unsigned size);
      ffha_pkg::req_type r;
      r.mode     = MODE_ALLOC;
      r.req_size = SW'(size);
      r.address  = AW'($urandom);
      return r;
   endfunction

   function automatic ffha_pkg::req_type make_release(int unsigned addr);
      ffha_pkg::req_type r;
      r.mode     = MODE_RELEASE;
      r.req_size = SW'($urandom);
      r.address  = AW'(addr);
      return r;
   endfunction

   // Picks a block size, mostly small so the tables fill and churn.
   function automatic int unsigned pick_size();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 60) return $urandom_range(64);
      if (sel < 85) return $urandom_range(2048);
      if (sel < 95) return $urandom_range(40000);
      return $urandom_range(2097151);
   endfunction

   // Picks a release address: a known grant, a stale one, null or noise.
   function automatic int unsigned pick_release();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 80 && granted_addrs.size() > 0)
         return granted_addrs[$urandom_range(granted_addrs.size() - 1)];
      if (sel < 88) return 0;
      return $urandom_range(1048575);
   endfunction

   // Driver: presents queued requests and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(heap_predict(req_data));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && !drain_hold &&
                (quiet_phase || $urandom_range(99) >= 6)) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         watchdog  <= 0;
      end else begin
         rsp_stall <= !quiet_phase && $urandom_range(99) < 6;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog <= 0;
         else watchdog <= watchdog + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: grant %0d status %0d",
                           rsp_data.grant_address, rsp_data.status);
            end else begin
               ffha_pkg::rsp_type want;
               want = expected_rsps.pop_front();
               if (want.grant_address !== rsp_data.grant_address ||
                   want.status !== rsp_data.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected grant %0d status %0d, got grant %0d status %0d",
                              want.grant_address, want.status,
                              rsp_data.grant_address, rsp_data.status);
               end
            end
         end
      end
   end

   // Watchdog on stalled progress.
   always @(posedge clock) begin
      if (!reset && watchdog >= WATCHDOG_LIMIT) begin
         $display("FAIL first_fit_heap_allocator");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      drain_hold  = 1'b0;
      quiet_phase = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: extremes, null and unknown releases, splits.
      pending_reqs.push_back(make_release(0));
      pending_reqs.push_back(make_release(20'hFFFFF));
      pending_reqs.push_back(make_alloc(0));
      pending_reqs.push_back(make_alloc(2097151));
      pending_reqs.push_back(make_alloc(1048576));
      pending_reqs.push_back(make_alloc(100));
      pending_reqs.push_back(make_alloc(40));
      pending_reqs.push_back(make_alloc(200));
      pending_reqs.push_back(make_release(HDR + HDR));
      pending_reqs.push_back(make_release(HDR + HDR));
      pending_reqs.push_back(make_alloc(10));
      pending_reqs.push_back(make_alloc(90));
      pending_reqs.push_back(make_release(HDR + HDR + 100 + HDR));
      pending_reqs.push_back(make_release(HDR));
      pending_reqs.push_back(make_alloc(1048576 - 1000));
      pending_reqs.push_back(make_alloc(2000));
      pending_reqs.push_back(make_release(20'h55555));
      pending_reqs.push_back(make_release(20'hAAAAA));
      while (pending_reqs.size() > 0) @(posedge clock);

      // Pause until every response is back.
      drain_hold <= 1'b1;
      while (expected_rsps.size() > 0 || req_valid) @(posedge clock);
      drain_hold <= 1'b0;

      // Random requests; allocation-heavy bursts then release-heavy bursts.
      for (int n = 0; n < 650; n++) begin
         bit rel;
         if (n == 200) quiet_phase <= 1'b1;
         if (n == 320) quiet_phase <= 1'b0;
         rel = ((n / 80) % 2 == 1) ? ($urandom_range(99) < 70)
                                   : ($urandom_range(99) < 30);
         while (pending_reqs.size() > 3) @(posedge clock);
         if (rel) pending_reqs.push_back(make_release(pick_release()));
         else pending_reqs.push_back(make_alloc(pick_size()));
      end
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("PASS first_fit_heap_allocator");
      else
         $display("FAIL first_fit_heap_allocator");
      $finish;
   end
endmodule

`default_nettype wire
